// ===== sv/bms_register_read_transaction_defines.svh =====
// Assertion macros for the register-read transaction checker.
`ifndef BMS_REGISTER_READ_TRANSACTION_DEFINES_SVH
`define BMS_REGISTER_READ_TRANSACTION_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define BMS_RRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define BMS_RRT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bms_rrt_pkg.sv =====
// Types, codes and the CRC-16 helper shared by the register-read transaction block.
package bms_rrt_pkg;

   // Sizing defaults
   localparam int MAX_REGS_DEFAULT    = 31;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Input word kinds
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Result word kinds
   localparam logic [1:0] OUT_TX     = 2'd0;
   localparam logic [1:0] OUT_WORD   = 2'd1;
   localparam logic [1:0] OUT_STATUS = 2'd2;

   // Completion status codes
   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_TIMEOUT = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN = 3'd2;
   localparam logic [2:0] STATUS_BAD_CRC = 3'd3;
   localparam logic [2:0] STATUS_BAD_HDR = 3'd4;

   // Frame constants
   localparam logic [7:0]  SOF_BYTE      = 8'hAA;
   localparam logic [7:0]  FUNC_READ     = 8'h07;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [5:0]  LEN_MASK      = 6'h3F;
   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Request frame byte positions
   localparam logic [2:0] TX_SOF     = 3'd0;
   localparam logic [2:0] TX_FUNC    = 3'd1;
   localparam logic [2:0] TX_COUNT   = 3'd2;
   localparam logic [2:0] TX_IDX_LO  = 3'd3;
   localparam logic [2:0] TX_IDX_HI  = 3'd4;
   localparam logic [2:0] TX_CRC_LO  = 3'd5;
   localparam logic [2:0] TX_CRC_HI  = 3'd6;

   // Input word
   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] reg_index;
      logic [4:0]  reg_count;
      logic [7:0]  rx_byte;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  tx_byte;
      logic [15:0] data_word;
      logic [4:0]  word_index;
      logic [2:0]  status;
      logic        last;
   } rsp_word_type;

   // Classified command held in the queue
   typedef enum logic [1:0] {
      CMD_START,
      CMD_BYTE,
      CMD_TICK
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] reg_index;
      logic [4:0]  reg_count;
      logic [7:0]  rx_byte;
   } cmd_entry_type;

   // One byte of CRC-16/Modbus, reflected polynomial
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/bms_rrt_front.sv =====
// Front end: accepts input words, classifies them and clamps the register count.
module bms_rrt_front
   import bms_rrt_pkg::*;
#(
   parameter int MAX_REGS = MAX_REGS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_data,
   output logic          q_push,
   output cmd_entry_type q_entry,
   input  logic          q_full
);

   localparam logic [4:0] MaxCount = 5'(MAX_REGS);

   logic accept;
   logic known;
   logic reset_seen_ff;

   // Hold off the input during reset and until reset_seen_ff is set once reset is low
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_seen_ff <= 1'b0;
      end else begin
         reset_seen_ff <= 1'b1;
      end
   end

   assign req_ready = reset_seen_ff && !q_full;
   assign accept    = req_valid && req_ready;

   // Classify; the unused kind is taken and dropped
   always_comb begin
      q_entry.reg_index = req_data.reg_index;
      q_entry.rx_byte   = req_data.rx_byte;
      q_entry.reg_count = (req_data.reg_count > MaxCount) ? MaxCount : req_data.reg_count;
      known             = 1'b1;
      case (req_data.req_type)
         REQ_START: q_entry.cmd = CMD_START;
         REQ_BYTE:  q_entry.cmd = CMD_BYTE;
         REQ_TICK:  q_entry.cmd = CMD_TICK;
         default: begin
            q_entry.cmd = CMD_TICK;
            known       = 1'b0;
         end
      endcase
   end

   assign q_push = accept && known;

endmodule

// ===== sv/bms_rrt_queue.sv =====
// Small FIFO of classified commands between the front and back ends.
module bms_rrt_queue
   import bms_rrt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output cmd_entry_type head,
   output logic          valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LastPtr  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(DEPTH);

   cmd_entry_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FullCnt);
   assign valid   = (count_ff != '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/bms_rrt_back.sv =====
// Back end: frame transmit, reply parser, payload store and result sequencer.
module bms_rrt_back
   import bms_rrt_pkg::*;
#(
   parameter int MAX_REGS = MAX_REGS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata,
   input  logic          q_valid,
   input  cmd_entry_type q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data
);

   localparam int ADDR_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam logic [4:0] MaxWords = 5'(MAX_REGS);

   typedef enum logic [2:0] {
      SQ_FETCH,
      SQ_TX,
      SQ_RD,
      SQ_WORD,
      SQ_STATUS
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_LEN,
      PH_DATA,
      PH_CRC
   } phase_type;

   seq_state_type seq_ff, seq_in;
   phase_type     phase_ff, phase_in;
   logic [15:0]   timeout_ff, timeout_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   tx_crc_ff, tx_crc_in;
   logic [5:0]    byte_cnt_ff, byte_cnt_in;
   logic [15:0]   timer_ff, timer_in;
   logic [4:0]    exp_cnt_ff, exp_cnt_in;
   logic [7:0]    low_hold_ff, low_hold_in;
   logic [15:0]   rx_crc_ff, rx_crc_in;
   logic [2:0]    tx_cnt_ff, tx_cnt_in;
   logic [15:0]   tx_index_ff, tx_index_in;
   logic [4:0]    word_idx_ff, word_idx_in;
   logic [2:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   logic [15:0]   mem [MAX_REGS];
   logic [15:0]   rd_data_ff;
   logic          mem_we;
   logic [4:0]    mem_waddr;
   logic [15:0]   mem_wdata;

   logic          out_free;
   logic [7:0]    rx_b;
   logic [15:0]   crc_rx;
   logic [15:0]   timer_inc;
   logic [5:0]    len_want;
   logic [5:0]    byte_cnt_nxt;
   logic [15:0]   rx_crc_full;
   logic [7:0]    tx_b;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rx_b         = q_head.rx_byte;
   assign crc_rx       = crc16_byte(crc_ff, rx_b);
   assign timer_inc    = (timer_ff != TIMER_MAX) ? timer_ff + 16'd1 : timer_ff;
   assign len_want     = {exp_cnt_ff, 1'b0};
   assign byte_cnt_nxt = byte_cnt_ff + 6'd1;
   assign rx_crc_full  = {rx_b, rx_crc_ff[7:0]};
   assign mem_waddr    = byte_cnt_ff[5:1];
   assign mem_wdata    = {rx_b, low_hold_ff};

   // Request frame byte mux
   always_comb begin
      case (tx_cnt_ff)
         TX_SOF:    tx_b = SOF_BYTE;
         TX_FUNC:   tx_b = FUNC_READ;
         TX_COUNT:  tx_b = {3'b000, exp_cnt_ff};
         TX_IDX_LO: tx_b = tx_index_ff[7:0];
         TX_IDX_HI: tx_b = tx_index_ff[15:8];
         TX_CRC_LO: tx_b = tx_crc_ff[7:0];
         TX_CRC_HI: tx_b = tx_crc_ff[15:8];
         default:   tx_b = 8'h00;
      endcase
   end

   // Sequencer and parser next state
   always_comb begin
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      timeout_in   = csr_we ? csr_wdata : timeout_ff;
      crc_in       = crc_ff;
      tx_crc_in    = tx_crc_ff;
      byte_cnt_in  = byte_cnt_ff;
      timer_in     = timer_ff;
      exp_cnt_in   = exp_cnt_ff;
      low_hold_in  = low_hold_ff;
      rx_crc_in    = rx_crc_ff;
      tx_cnt_in    = tx_cnt_ff;
      tx_index_in  = tx_index_ff;
      word_idx_in  = word_idx_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;

      case (seq_ff)
         // Take one command from the queue and act on it
         SQ_FETCH: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_head.cmd)
                  CMD_START: begin
                     exp_cnt_in  = q_head.reg_count;
                     tx_index_in = q_head.reg_index;
                     tx_crc_in   = CRC_INIT;
                     tx_cnt_in   = TX_SOF;
                     crc_in      = CRC_INIT;
                     rx_crc_in   = '0;
                     low_hold_in = '0;
                     phase_in    = PH_HDR;
                     byte_cnt_in = '0;
                     timer_in    = '0;
                     seq_in      = SQ_TX;
                  end
                  CMD_TICK: begin
                     if (phase_ff != PH_IDLE) begin
                        timer_in = timer_inc;
                        if (timer_inc >= timeout_ff) begin
                           phase_in  = PH_IDLE;
                           status_in = STATUS_TIMEOUT;
                           seq_in    = SQ_STATUS;
                        end
                     end
                  end
                  CMD_BYTE: begin
                     case (phase_ff)
                        PH_IDLE: begin
                        end
                        PH_HDR: begin
                           crc_in = crc_rx;
                           if (byte_cnt_ff == '0) begin
                              low_hold_in = rx_b;
                              byte_cnt_in = 6'd1;
                           end else if (low_hold_ff == SOF_BYTE && rx_b != 8'h00) begin
                              phase_in    = PH_LEN;
                              byte_cnt_in = '0;
                              timer_in    = '0;
                           end else begin
                              phase_in  = PH_IDLE;
                              status_in = STATUS_BAD_HDR;
                              seq_in    = SQ_STATUS;
                           end
                        end
                        PH_LEN: begin
                           crc_in = crc_rx;
                           if ((rx_b[5:0] & LEN_MASK) != len_want) begin
                              phase_in  = PH_IDLE;
                              status_in = STATUS_BAD_LEN;
                              seq_in    = SQ_STATUS;
                           end else begin
                              phase_in    = (len_want != '0) ? PH_DATA : PH_CRC;
                              byte_cnt_in = '0;
                              timer_in    = '0;
                           end
                        end
                        PH_DATA: begin
                           crc_in = crc_rx;
                           if (!byte_cnt_ff[0]) begin
                              low_hold_in = rx_b;
                           end else if (mem_waddr < MaxWords) begin
                              mem_we = 1'b1;
                           end
                           if (byte_cnt_nxt >= len_want) begin
                              phase_in    = PH_CRC;
                              byte_cnt_in = '0;
                              timer_in    = '0;
                           end else begin
                              byte_cnt_in = byte_cnt_nxt;
                           end
                        end
                        PH_CRC: begin
                           if (byte_cnt_ff == '0) begin
                              rx_crc_in   = {8'h00, rx_b};
                              byte_cnt_in = 6'd1;
                           end else begin
                              rx_crc_in = rx_crc_full;
                              phase_in  = PH_IDLE;
                              if (rx_crc_full != crc_ff) begin
                                 status_in = STATUS_BAD_CRC;
                                 seq_in    = SQ_STATUS;
                              end else begin
                                 status_in   = STATUS_OK;
                                 word_idx_in = '0;
                                 seq_in      = (exp_cnt_ff == '0) ? SQ_STATUS : SQ_RD;
                              end
                           end
                        end
                        default: phase_in = PH_IDLE;
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Send the seven request bytes, folding the first five into the CRC
         SQ_TX: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in.out_kind = OUT_TX;
               rsp_data_in.tx_byte  = tx_b;
               if (tx_cnt_ff < TX_CRC_LO) begin
                  tx_crc_in = crc16_byte(tx_crc_ff, tx_b);
               end
               if (tx_cnt_ff == TX_CRC_HI) begin
                  seq_in = SQ_FETCH;
               end else begin
                  tx_cnt_in = tx_cnt_ff + 3'd1;
               end
            end
         end
         // Wait here while the registered payload store read completes
         SQ_RD: begin
            seq_in = SQ_WORD;
         end
         SQ_WORD: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = '0;
               rsp_data_in.out_kind   = OUT_WORD;
               rsp_data_in.data_word  = rd_data_ff;
               rsp_data_in.word_index = word_idx_ff;
               if (word_idx_ff + 5'd1 == exp_cnt_ff) begin
                  seq_in = SQ_STATUS;
               end else begin
                  word_idx_in = word_idx_ff + 5'd1;
                  seq_in      = SQ_RD;
               end
            end
         end
         SQ_STATUS: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in.out_kind = OUT_STATUS;
               rsp_data_in.status   = status_ff;
               rsp_data_in.last     = 1'b1;
               seq_in               = SQ_FETCH;
            end
         end
         default: seq_in = SQ_FETCH;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_FETCH;
         phase_ff     <= PH_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         crc_ff       <= CRC_INIT;
         byte_cnt_ff  <= '0;
         timer_ff     <= '0;
         exp_cnt_ff   <= '0;
         low_hold_ff  <= '0;
         rx_crc_ff    <= '0;
         tx_cnt_ff    <= '0;
         word_idx_ff  <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         timeout_ff   <= timeout_in;
         crc_ff       <= crc_in;
         byte_cnt_ff  <= byte_cnt_in;
         timer_ff     <= timer_in;
         exp_cnt_ff   <= exp_cnt_in;
         low_hold_ff  <= low_hold_in;
         rx_crc_ff    <= rx_crc_in;
         tx_cnt_ff    <= tx_cnt_in;
         word_idx_ff  <= word_idx_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tx_crc_ff   <= tx_crc_in;
      tx_index_ff <= tx_index_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Payload store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
      end
      if (seq_ff == SQ_RD) begin
         rd_data_ff <= mem[word_idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/bms_register_read_transaction.sv =====
// Top level of the register-read transaction master.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_ready  req_data  (req_word_type)
//   rsp_*        out   rsp_valid/rsp_ready  rsp_data  (rsp_word_type)
//   csr_*        in    csr_we               csr_wdata (timeout in ticks)
//
// In the back end, a byte or tick that keeps the exchange running is handled in
// fetch alone, one that ends it with an error or timeout in fetch and status, a
// start word in fetch and then in the transmit of each request byte, and the
// last CRC byte of a good reply in fetch, a read and output per word, and status.
// Synchronous reset clears all control state; the payload store is not cleared.
// A command queue, two deep by default, lets input words arrive while results are stalled.
module bms_register_read_transaction
   import bms_rrt_pkg::*;
#(
   parameter int MAX_REGS    = MAX_REGS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   logic          q_push;
   cmd_entry_type q_entry;
   logic          q_full;
   logic          q_pop;
   cmd_entry_type q_head;
   logic          q_valid;

   // Classify incoming words
   bms_rrt_front #(.MAX_REGS(MAX_REGS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_entry   (q_entry),
      .q_full    (q_full)
   );

   // Decouple front and back
   bms_rrt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .valid     (q_valid)
   );

   // Transmit, parse and emit
   bms_rrt_back #(.MAX_REGS(MAX_REGS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/bms_rrt_checker.sv =====
// Port-level assertion checker for the register-read transaction master, with its bind.
`include "bms_register_read_transaction_defines.svh"

module bms_rrt_checker
   import bms_rrt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // A stalled result word stays offered
   `BMS_RRT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // A stalled result word keeps its payload
   `BMS_RRT_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed")

   // Nothing is offered right after reset
   `BMS_RRT_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "rsp after reset")

   // Only completion words carry a status or the last flag
   `BMS_RRT_ASSERT_IMP(a_last_on_status, clock, reset, rsp_valid && rsp_data.out_kind != OUT_STATUS, rsp_data.status == STATUS_OK && !rsp_data.last, "status on data")

endmodule

bind bms_register_read_transaction bms_rrt_checker u_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the register-read transaction master: directed table plus random replies.
module tb;
   import bms_rrt_pkg::*;

   localparam int         PERIOD        = 10;
   localparam int         RESET_CYCLES  = 4;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         RANDOM_ITEMS  = 80;
   localparam int         PHASE_ITEMS   = 24;
   localparam int         RUN_LIMIT     = 5000000;
   localparam logic [1:0] REQ_UNUSED    = 2'd3;

   // How the expectation of a word is formed
   typedef enum logic [1:0] {FORM_PREDICT, FORM_NONE, FORM_STATUS} form_type;
   typedef enum logic {ROW_SEND, ROW_CFG} row_op_type;
   typedef enum logic [2:0] {P_IDLE, P_HEADER, P_LENGTH, P_PAYLOAD, P_CHECK} link_phase_type;
   typedef enum logic [2:0] {
      RUN_GOOD, RUN_BAD_HDR, RUN_BAD_LEN, RUN_BAD_CRC, RUN_TIMEOUT, RUN_ABANDON
   } run_kind_type;

   // One row of the directed table; a config row carries its value in reg_index
   typedef struct packed {
      row_op_type   op;
      req_word_type w;
      form_type     form;
      logic [2:0]   st;
   } plan_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_word_type req_data    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we      = 1'b0;
   logic [15:0]  csr_wdata   = '0;

   // Side info traveling with the current input word
   form_type     word_form   = FORM_PREDICT;
   logic [2:0]   word_status = STATUS_OK;

   // Predictor state
   logic [15:0]    tick_limit  = TIMEOUT_RESET;
   link_phase_type link_phase  = P_IDLE;
   logic [15:0]    link_crc    = CRC_INIT;
   logic [5:0]     link_pos    = '0;
   logic [15:0]    link_timer  = '0;
   logic [4:0]     link_count  = '0;
   logic [7:0]     link_hold   = '0;
   logic [15:0]    link_rx_crc = '0;
   logic [15:0]    link_words [31];

   rsp_word_type step_rsp[$];
   rsp_word_type pending_rsp[$];
   plan_row_type plan[$];

   int errors       = 0;
   int random_items = 0;
   bit tally        = 1'b0;
   bit calm         = 1'b0;
   bit idle_on      = 1'b1;
   bit link_quiet   = 1'b1;
   int ready_hold   = 0;
   int stretch_left = 0;

   bms_register_read_transaction u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // CRC-16/Modbus, one data bit at a time, LSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   // Random word of a given kind; unused fields carry noise
   function automatic req_word_type filler(input logic [1:0] kind);
      logic [31:0]  bits;
      req_word_type w;
      bits = $urandom;
      w = bits[$bits(req_word_type)-1:0];
      w.req_type = kind;
      return w;
   endfunction

   function automatic void add_row(input row_op_type op, input logic [1:0] kind,
                                   input logic [15:0] idx, input logic [4:0] cnt,
                                   input logic [7:0] b, input form_type form,
                                   input logic [2:0] st);
      plan_row_type r;
      r.op          = op;
      r.w.req_type  = kind;
      r.w.reg_index = idx;
      r.w.reg_count = cnt;
      r.w.rx_byte   = b;
      r.form        = form;
      r.st          = st;
      plan.push_back(r);
   endfunction

   task automatic post(input logic [1:0] kind, input logic [7:0] tx, input logic [15:0] word,
                       input logic [4:0] idx, input logic [2:0] st, input logic last);
      rsp_word_type r;
      r.out_kind   = kind;
      r.tx_byte    = tx;
      r.data_word  = word;
      r.word_index = idx;
      r.status     = st;
      r.last       = last;
      step_rsp.push_back(r);
   endtask

   task automatic close_link(input logic [2:0] st);
      link_phase = P_IDLE;
      post(OUT_STATUS, 8'h00, 16'h0000, 5'd0, st, 1'b1);
   endtask

   // Each awaited chunk restarts its byte position and tick timer
   task automatic open_chunk(input link_phase_type ph);
      link_phase = ph;
      link_pos   = '0;
      link_timer = '0;
   endtask

   // Predictor: one accepted word in, its results into step_rsp
   task automatic advance_link(input req_word_type w);
      logic [7:0]  frame [7];
      logic [15:0] c;
      logic [7:0]  b;
      logic [5:0]  span;
      step_rsp.delete();
      if (w.req_type == REQ_START) begin
         frame[0] = SOF_BYTE;
         frame[1] = FUNC_READ;
         frame[2] = {3'b000, w.reg_count};
         frame[3] = w.reg_index[7:0];
         frame[4] = w.reg_index[15:8];
         c = CRC_INIT;
         for (int k = 0; k < 5; k++) c = crc16_step(c, frame[k]);
         frame[5] = c[7:0];
         frame[6] = c[15:8];
         for (int k = 0; k < 7; k++) post(OUT_TX, frame[k], 16'h0000, 5'd0, STATUS_OK, 1'b0);
         link_count  = w.reg_count;
         link_crc    = CRC_INIT;
         link_rx_crc = '0;
         link_hold   = '0;
         open_chunk(P_HEADER);
      end else if (link_phase == P_IDLE || w.req_type == REQ_UNUSED) begin
         // dropped
      end else if (w.req_type == REQ_TICK) begin
         if (link_timer != TIMER_MAX) link_timer = link_timer + 16'd1;
         if (link_timer >= tick_limit) close_link(STATUS_TIMEOUT);
      end else begin
         b    = w.rx_byte;
         span = {link_count, 1'b0};
         case (link_phase)
            P_HEADER: begin
               link_crc = crc16_step(link_crc, b);
               if (link_pos == 6'd0) begin
                  link_hold = b;
                  link_pos  = 6'd1;
               end else if (link_hold == SOF_BYTE && b != 8'h00) begin
                  open_chunk(P_LENGTH);
               end else begin
                  close_link(STATUS_BAD_HDR);
               end
            end
            P_LENGTH: begin
               link_crc = crc16_step(link_crc, b);
               if ((b[5:0] & LEN_MASK) != span) close_link(STATUS_BAD_LEN);
               else open_chunk(span != 6'd0 ? P_PAYLOAD : P_CHECK);
            end
            P_PAYLOAD: begin
               link_crc = crc16_step(link_crc, b);
               if (!link_pos[0]) link_hold = b;
               else link_words[link_pos[5:1]] = {b, link_hold};
               link_pos = link_pos + 6'd1;
               if (link_pos >= span) open_chunk(P_CHECK);
            end
            P_CHECK: begin
               if (link_pos == 6'd0) begin
                  link_rx_crc = {8'h00, b};
                  link_pos    = 6'd1;
               end else begin
                  link_rx_crc[15:8] = b;
                  if (link_rx_crc != link_crc) begin
                     close_link(STATUS_BAD_CRC);
                  end else begin
                     for (int k = 0; k < link_count; k++)
                        post(OUT_WORD, 8'h00, link_words[k], 5'(k), STATUS_OK, 1'b0);
                     close_link(STATUS_OK);
                  end
               end
            end
            default: link_phase = P_IDLE;
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // Monitor: predict on input acceptance, check on result acceptance
   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_link(req_data);
            case (word_form)
               FORM_PREDICT: foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
               FORM_STATUS: begin
                  want          = '0;
                  want.out_kind = OUT_STATUS;
                  want.status   = word_status;
                  want.last     = 1'b1;
                  pending_rsp.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_data);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("out_kind", 16'(want.out_kind), 16'(rsp_data.out_kind));
               check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_data.tx_byte));
               check_field("data_word", want.data_word, rsp_data.data_word);
               check_field("word_index", 16'(want.word_index), 16'(rsp_data.word_index));
               check_field("status", 16'(want.status), 16'(rsp_data.status));
               check_field("last", 16'(want.last), 16'(rsp_data.last));
            end
         end
      end
   end

   // Receiver: stall bursts inside stretches that either allow them or not
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stretch_left <= $urandom_range(20, 200);
         idle_on      <= ($urandom_range(0, 2) != 0);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
         ready_hold <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   task automatic send_word(input req_word_type w, input form_type form, input logic [2:0] st);
      if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= w;
      word_form   <= form;
      word_status <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (tally && w.req_type != REQ_UNUSED) random_items++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_word_type w;
      w = filler(REQ_BYTE);
      w.rx_byte = b;
      send_word(w, FORM_PREDICT, STATUS_OK);
   endtask

   // Hold off until every result is in, then let queued no-result words drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      csr_we     <= 1'b1;
      csr_wdata  <= v;
      tick_limit  = v;
      @(posedge clock);
      csr_we     <= 1'b0;
   endtask

   // One random exchange: start, then a reply that is good, broken, stalled or cut short
   task automatic run_exchange();
      logic [7:0]   reply[$];
      logic [4:0]   cnt;
      logic [15:0]  crc;
      req_word_type w;
      run_kind_type run;
      int           cut;
      int           budget;
      int           k;
      calm <= (random_items >= RANDOM_ITEMS - 15);

      // noise while idle
      if (link_quiet && $urandom_range(0, 4) == 0) begin
         tally = 1'b0;
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0:       w = filler(REQ_BYTE);
               1:       w = filler(REQ_TICK);
               default: w = filler(REQ_UNUSED);
            endcase
            send_word(w, FORM_PREDICT, STATUS_OK);
         end
         tally = 1'b1;
      end

      // mostly small counts, now and then the largest
      case ($urandom_range(0, 11))
         0:       cnt = 5'd31;
         1:       cnt = 5'($urandom_range(5, 30));
         default: cnt = 5'($urandom_range(0, 4));
      endcase
      w = filler(REQ_START);
      w.reg_count = cnt;
      send_word(w, FORM_PREDICT, STATUS_OK);

      reply.delete();
      reply.push_back(SOF_BYTE);
      reply.push_back(8'($urandom_range(1, 255)));
      reply.push_back({2'($urandom_range(0, 3)), cnt, 1'b0});
      for (k = 0; k < 2 * int'(cnt); k++) reply.push_back(8'($urandom));
      crc = CRC_INIT;
      for (k = 0; k < reply.size(); k++) crc = crc16_step(crc, reply[k]);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);

      case ($urandom_range(0, 11))
         0:       run = RUN_BAD_HDR;
         1:       run = RUN_BAD_LEN;
         2:       run = RUN_BAD_CRC;
         3:       run = (tick_limit <= 16'd8) ? RUN_TIMEOUT : RUN_GOOD;
         4:       run = RUN_ABANDON;
         default: run = RUN_GOOD;
      endcase

      cut = reply.size();
      case (run)
         RUN_BAD_HDR: begin
            if ($urandom_range(0, 1) != 0) reply[0] = reply[0] ^ 8'($urandom_range(1, 255));
            else reply[1] = 8'h00;
            cut = 2;
         end
         RUN_BAD_LEN: begin
            reply[2][5:0] = reply[2][5:0] ^ 6'($urandom_range(1, 63));
            cut = 3;
         end
         RUN_BAD_CRC: begin
            k = $urandom_range(0, reply.size() - 1);
            reply[k] = reply[k] ^ 8'($urandom_range(1, 255));
         end
         RUN_TIMEOUT, RUN_ABANDON: cut = $urandom_range(0, reply.size() - 1);
         default: ;
      endcase

      // ticks stay below the limit in every chunk unless a timeout is the aim
      budget = 0;
      for (k = 0; k < cut; k++) begin
         if (k == 0 || k == 2 || k == 3 || k == 3 + 2 * int'(cnt))
            budget = (tick_limit > 16'd4) ? 3 : int'(tick_limit) - 1;
         while (run != RUN_TIMEOUT && budget > 0 && $urandom_range(0, 2) == 0) begin
            send_word(filler(REQ_TICK), FORM_PREDICT, STATUS_OK);
            budget--;
         end
         if ($urandom_range(0, 15) == 0) send_word(filler(REQ_UNUSED), FORM_PREDICT, STATUS_OK);
         send_byte(reply[k]);
      end
      if (run == RUN_TIMEOUT)
         repeat (int'(tick_limit)) send_word(filler(REQ_TICK), FORM_PREDICT, STATUS_OK);
      link_quiet = (run != RUN_ABANDON);
   endtask

   initial begin : stimulus
      logic [15:0] crc_empty;
      logic [15:0] crc_one;
      logic [15:0] limit;
      int          goal;
      int          p;

      // reply CRCs for the directed rows
      crc_empty = CRC_INIT;
      crc_empty = crc16_step(crc_empty, 8'hAA);
      crc_empty = crc16_step(crc_empty, 8'hFF);
      crc_empty = crc16_step(crc_empty, 8'hC0);
      crc_one = CRC_INIT;
      crc_one = crc16_step(crc_one, 8'hAA);
      crc_one = crc16_step(crc_one, 8'h01);
      crc_one = crc16_step(crc_one, 8'h02);
      crc_one = crc16_step(crc_one, 8'h34);
      crc_one = crc16_step(crc_one, 8'h12);

      // idle input is dropped
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hFF, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_TICK,   16'h0000, 5'd0,  8'h00, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_UNUSED, 16'hFFFF, 5'd31, 8'hFF, FORM_NONE, STATUS_OK);
      // zero count, second header byte zero
      add_row(ROW_SEND, REQ_START,  16'h0000, 5'd0,  8'h00, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hAA, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h00, FORM_STATUS, STATUS_BAD_HDR);
      // full count, then a restart while busy, then a wrong length
      add_row(ROW_SEND, REQ_START,  16'hFFFF, 5'd31, 8'hFF, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_START,  16'h1234, 5'd1,  8'h00, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hAA, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h80, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h05, FORM_STATUS, STATUS_BAD_LEN);
      // empty reply, length high bits set, straight to CRC
      add_row(ROW_SEND, REQ_START,  16'hA5A5, 5'd0,  8'h00, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hAA, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hFF, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hC0, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  crc_empty[7:0], FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  crc_empty[15:8], FORM_PREDICT, STATUS_OK);
      // one word with a corrupted CRC
      add_row(ROW_SEND, REQ_START,  16'h00FF, 5'd1,  8'h00, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'hAA, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h01, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h02, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h34, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  8'h12, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  crc_one[7:0] ^ 8'h01, FORM_NONE,
              STATUS_OK);
      add_row(ROW_SEND, REQ_BYTE,   16'h0000, 5'd0,  crc_one[15:8], FORM_STATUS, STATUS_BAD_CRC);
      // shortest timeout: first tick ends the exchange
      add_row(ROW_CFG,  REQ_START,  16'd1,    5'd0,  8'h00, FORM_NONE, STATUS_OK);
      add_row(ROW_SEND, REQ_START,  16'h5A5A, 5'd2,  8'h00, FORM_PREDICT, STATUS_OK);
      add_row(ROW_SEND, REQ_TICK,   16'h0000, 5'd0,  8'h00, FORM_STATUS, STATUS_TIMEOUT);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].op == ROW_CFG) begin
            settle();
            write_timeout(plan[i].w.reg_index);
         end else begin
            send_word(plan[i].w, plan[i].form, plan[i].st);
         end
      end

      // random phases, each under its own timeout setting
      tally = 1'b1;
      p = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (p % 5)
            0:       limit = 16'hFFFF;
            2:       limit = TIMEOUT_RESET;
            3:       limit = 16'd1;
            default: limit = 16'($urandom_range(2, 8));
         endcase
         settle();
         write_timeout(limit);
         goal = random_items + PHASE_ITEMS;
         run_exchange();
         while ((random_items < goal && random_items < RANDOM_ITEMS) || !link_quiet)
            run_exchange();
         p++;
      end

      settle();
      if (errors == 0) begin
         $display("bms_register_read_transaction test passed");
      end else begin
         $display("bms_register_read_transaction test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("bms_register_read_transaction test failed");
      $finish;
   end

endmodule
